/* hdl/hsfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_pkg
// Types and constants shared by the header sync frame receiver.
// ----------------------------------------------------------------------------
package hsfr_pkg;

	localparam int BUF_DEPTH   = 15;
	localparam int LEVEL_COUNT = 9;
	localparam int LEVEL_BASE  = 5;
	localparam int CHECK_POS   = 14;
	localparam int WIN_LAST    = 4;

	localparam logic [7:0] SYNC_HI    = 8'hFF;
	localparam logic [7:0] SYNC_LO    = 8'h00;
	localparam logic [7:0] TYPE_FULL  = 8'd1;
	localparam logic [7:0] TYPE_SHORT = 8'd2;

	localparam logic [3:0] FIRST_POS  = 4'd5;
	localparam logic [3:0] LAST_FULL  = 4'd14;
	localparam logic [3:0] LAST_SHORT = 4'd10;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [7:0]  frame_type;
		logic [7:0]  level_0;
		logic [7:0]  level_1;
		logic [7:0]  level_2;
		logic [7:0]  level_3;
		logic [7:0]  level_4;
		logic [7:0]  level_5;
		logic [7:0]  level_6;
		logic [7:0]  level_7;
		logic [7:0]  level_8;
		logic [7:0]  frame_check;
		logic [15:0] frames_seen;
	} frame_item_t;

	// input register contents handed to the deframer
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} rx_stage_t;

	// deframer outcome for the byte processed this cycle
	typedef struct packed {
		logic        done;
		frame_item_t item;
	} core_res_t;

endpackage

/* hdl/hsfr_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface hsfr_stream_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/hsfr_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_in_stage
// Input register: holds one received byte until the deframer takes it.
// ----------------------------------------------------------------------------
module hsfr_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	hsfr_stream_if.sink       rx_chan,
	input  logic              take,
	output hsfr_pkg::rx_stage_t stage
);
	import hsfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign rx_chan.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_chan.ready) begin
			valid_s1 <= rx_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_chan.valid && rx_chan.ready) begin
			byte_s1 <= rx_chan.data.rx_byte;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

/* hdl/hsfr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_core
// Deframer state: header window, frame buffer, held levels, frame counter.
// Processes one byte per cycle when fire is high.
// ----------------------------------------------------------------------------
module hsfr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          rx_byte,
	output hsfr_pkg::core_res_t res
);
	import hsfr_pkg::*;

	logic [7:0]  buf_q    [BUF_DEPTH];
	logic [7:0]  buf_nx   [BUF_DEPTH];
	logic [7:0]  level_q  [LEVEL_COUNT];
	logic [7:0]  level_nx [LEVEL_COUNT];
	logic [7:0]  check_q, check_nx;
	logic [15:0] total_q, total_nx;
	logic        collect_q, collect_nx;
	logic [3:0]  wpos_q, wpos_nx;
	logic [3:0]  last_q, last_nx;
	logic        store;
	logic        done;

	always_comb begin
		buf_nx     = buf_q;
		level_nx   = level_q;
		check_nx   = check_q;
		total_nx   = total_q;
		collect_nx = collect_q;
		wpos_nx    = wpos_q;
		last_nx    = last_q;
		store      = 1'b0;
		done       = 1'b0;
		if (!collect_q) begin
			for (int i = 0; i < WIN_LAST; i++) begin
				buf_nx[i] = buf_q[i + 1];
			end
			buf_nx[WIN_LAST] = rx_byte;
			// header check on the shifted window
			if (buf_q[1] == SYNC_HI && buf_q[2] == SYNC_LO &&
					buf_q[3] == SYNC_HI && buf_q[4] == SYNC_LO) begin
				collect_nx = 1'b1;
				wpos_nx    = FIRST_POS;
				if (rx_byte == TYPE_FULL) begin
					last_nx = LAST_FULL;
				end else if (rx_byte == TYPE_SHORT) begin
					last_nx = LAST_SHORT;
				end
			end
		end else begin
			store = (wpos_q <= last_q);
			if (store) begin
				for (int i = 0; i < BUF_DEPTH; i++) begin
					if (wpos_q == 4'(i)) begin
						buf_nx[i] = rx_byte;
					end
				end
				wpos_nx = wpos_q + 4'd1;
			end
			if (!(wpos_nx <= last_q)) begin
				done       = 1'b1;
				collect_nx = 1'b0;
				if (buf_q[WIN_LAST] == TYPE_FULL) begin
					for (int i = 0; i < LEVEL_COUNT; i++) begin
						level_nx[i] = buf_nx[LEVEL_BASE + i];
					end
					check_nx = buf_nx[CHECK_POS];
				end
				total_nx = total_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				buf_q[i] <= '0;
			end
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				level_q[i] <= '0;
			end
			check_q   <= '0;
			total_q   <= '0;
			collect_q <= 1'b0;
			wpos_q    <= '0;
			last_q    <= '0;
		end else if (fire) begin
			buf_q     <= buf_nx;
			level_q   <= level_nx;
			check_q   <= check_nx;
			total_q   <= total_nx;
			collect_q <= collect_nx;
			wpos_q    <= wpos_nx;
			last_q    <= last_nx;
		end
	end

	assign res.done                  = done;
	assign res.item.frame_type       = buf_q[WIN_LAST];
	assign res.item.level_0          = level_nx[0];
	assign res.item.level_1          = level_nx[1];
	assign res.item.level_2          = level_nx[2];
	assign res.item.level_3          = level_nx[3];
	assign res.item.level_4          = level_nx[4];
	assign res.item.level_5          = level_nx[5];
	assign res.item.level_6          = level_nx[6];
	assign res.item.level_7          = level_nx[7];
	assign res.item.level_8          = level_nx[8];
	assign res.item.frame_check      = check_nx;
	assign res.item.frames_seen      = total_nx;

endmodule

/* hdl/header_sync_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// A byte that completes a frame passes through the input register and then the result
// register before its result shows on frame_chan.
// Throughput: one byte per cycle while the result side is ready; the input register
// and the result register let one byte in while a result waits.
// Reset (arst_n low, asynchronous): window, frame buffer, held levels, checksum and
// frame counter clear to zero; the receiver idles searching for FF 00 FF 00.
// ----------------------------------------------------------------------------
// header_sync_frame_receiver_unit
// Serial frame deframer: header sync, frame collection, level latch, result reg.
// ----------------------------------------------------------------------------
module header_sync_frame_receiver_unit (
	input  logic          clk,
	input  logic          arst_n,
	hsfr_stream_if.sink   rx_chan,
	hsfr_stream_if.source frame_chan
);
	import hsfr_pkg::*;

	rx_stage_t   stage;
	core_res_t   res;
	logic        fire;
	logic        out_valid_q;
	frame_item_t out_data_q;

	assign fire = stage.valid && (!out_valid_q || frame_chan.ready);

	hsfr_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_chan (rx_chan),
		.take    (fire),
		.stage   (stage)
	);

	hsfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (stage.rx_byte),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.done) begin
			out_valid_q <= 1'b1;
		end else if (frame_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.done) begin
			out_data_q <= res.item;
		end
	end

	assign frame_chan.valid = out_valid_q;
	assign frame_chan.data  = out_data_q;

endmodule

/* hdl/hsfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module hsfr_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rx_valid,
	input logic                  rx_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input hsfr_pkg::frame_item_t out_data
);
	import hsfr_pkg::*;

	logic        out_acc;
	logic [15:0] count_q;
	logic [7:0]  lvl0_q;
	logic [7:0]  check_q;

	assign out_acc = out_valid && out_ready;

	// last delivered counter and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lvl0_q  <= '0;
			check_q <= '0;
		end else if (out_acc) begin
			count_q <= out_data.frames_seen;
			lvl0_q  <= out_data.level_0;
			check_q <= out_data.frame_check;
		end
	end

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> out_data.frames_seen == count_q + 16'd1)
		else $error("frame count did not advance by one");

	a_hold_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_data.frame_type != TYPE_FULL |->
			out_data.level_0 == lvl0_q && out_data.frame_check == check_q)
		else $error("held values changed on a non-level frame");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	a_rx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && !rx_ready |=> rx_valid)
		else $error("rx item withdrawn");

endmodule

bind header_sync_frame_receiver_unit hsfr_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx_chan.valid),
	.rx_ready  (rx_chan.ready),
	.out_valid (frame_chan.valid),
	.out_ready (frame_chan.ready),
	.out_data  (frame_chan.data)
);

/* bench/tb_header_sync_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_header_sync_frame_receiver_unit
// Byte stream in, frame results out. A deframer model in the bench tracks the
// header window, collection and held levels for every accepted byte, and each
// result is checked field by field against the oldest predicted frame. Runs a
// few minimal frames while the last index is still zero, a few directed frames,
// then random frames with noise, random idling on both sides and one long
// result-side hold-off.
// ----------------------------------------------------------------------------
module tb_header_sync_frame_receiver_unit;
	import hsfr_pkg::*;

	localparam int ZERO_LAST_FRAMES = 8;
	localparam int RAND_BYTES       = 440;
	localparam int RAND_FRAMES      = 40;
	localparam int TAIL_ITEMS       = 60;
	localparam int HOLD_CYCLES      = 300;
	localparam int CYCLE_LIMIT      = 1000000;

	logic clk = 1'b0;
	logic arst_n;

	hsfr_stream_if #(.T(rx_item_t))    rx_if ();
	hsfr_stream_if #(.T(frame_item_t)) frame_if ();

	header_sync_frame_receiver_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_chan    (rx_if.sink),
		.frame_chan (frame_if.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [7:0]  rx_pending [$];
	frame_item_t frame_expect [$];

	// directed payloads: nine levels then checksum, and six short-frame bytes
	logic [7:0] kind_list_full [10] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
	                                    8'h80, 8'h7F, 8'hFE, 8'h02, 8'hFF};
	logic [7:0] kind_list_short [6] = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};

	// deframer model state
	logic [7:0]  win_buf [BUF_DEPTH];
	logic        collecting;
	logic [3:0]  wr_pos;
	logic [3:0]  last_pos;
	logic [7:0]  held_level [LEVEL_COUNT];
	logic [7:0]  held_check;
	logic [15:0] frame_count;

	int bytes_taken;
	int idle_from;
	int hold_at;
	int send_gap;
	int stall_left;
	int hold_left;
	bit hold_done;
	int mismatch_cnt;
	int frames_checked;
	int cycle_cnt;

	function automatic bit idling_allowed();
		return bytes_taken >= idle_from && rx_pending.size() > TAIL_ITEMS;
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? SYNC_HI : SYNC_LO;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void queue_header(logic [7:0] kind);
		rx_pending.push_back(SYNC_HI);
		rx_pending.push_back(SYNC_LO);
		rx_pending.push_back(SYNC_HI);
		rx_pending.push_back(SYNC_LO);
		rx_pending.push_back(kind);
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		frame_item_t r;
		if (!collecting) begin
			for (int i = 0; i < WIN_LAST; i++)
				win_buf[i] = win_buf[i + 1];
			win_buf[WIN_LAST] = b;
			if (win_buf[0] == SYNC_HI && win_buf[1] == SYNC_LO &&
			    win_buf[2] == SYNC_HI && win_buf[3] == SYNC_LO) begin
				collecting = 1'b1;
				wr_pos = FIRST_POS;
				if (win_buf[WIN_LAST] == TYPE_FULL)
					last_pos = LAST_FULL;
				else if (win_buf[WIN_LAST] == TYPE_SHORT)
					last_pos = LAST_SHORT;
			end
		end else begin
			if (wr_pos <= last_pos) begin
				win_buf[wr_pos] = b;
				wr_pos = wr_pos + 4'd1;
			end
			if (wr_pos > last_pos) begin
				collecting = 1'b0;
				if (win_buf[WIN_LAST] == TYPE_FULL) begin
					for (int i = 0; i < LEVEL_COUNT; i++)
						held_level[i] = win_buf[LEVEL_BASE + i];
					held_check = win_buf[CHECK_POS];
				end
				frame_count = frame_count + 16'd1;
				r.frame_type  = win_buf[WIN_LAST];
				r.level_0     = held_level[0];
				r.level_1     = held_level[1];
				r.level_2     = held_level[2];
				r.level_3     = held_level[3];
				r.level_4     = held_level[4];
				r.level_5     = held_level[5];
				r.level_6     = held_level[6];
				r.level_7     = held_level[7];
				r.level_8     = held_level[8];
				r.frame_check = held_check;
				r.frames_seen = frame_count;
				frame_expect.push_back(r);
			end
		end
	endtask

	task automatic note_mismatch(input string what, input logic [15:0] want,
	                             input logic [15:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("frame %0d %s: expected %0h, got %0h", frames_checked, what, want, got);
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
	                           input logic [15:0] got);
		if (got !== want)
			note_mismatch(what, want, got);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		logic       offer;
		logic [7:0] next_byte;
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.data  <= '0;
			send_gap    <= 0;
		end else begin
			offer     = rx_if.valid;
			next_byte = rx_if.data.rx_byte;
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.data.rx_byte);
				bytes_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
				end else if (rx_pending.size() != 0) begin
					// keep offering while the result side is held off
					if (idling_allowed() && hold_left == 0 && $urandom_range(0, 7) == 0) begin
						send_gap <= $urandom_range(0, 15);
					end else begin
						offer     = 1'b1;
						next_byte = rx_pending.pop_front();
					end
				end
			end
			rx_if.valid <= offer;
			rx_if.data  <= next_byte;
		end
	end

	// result side ready, with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
			stall_left     <= 0;
			hold_left      <= 0;
			hold_done      <= 1'b0;
		end else if (!hold_done && bytes_taken >= hold_at) begin
			hold_done      <= 1'b1;
			hold_left      <= HOLD_CYCLES;
			frame_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left      <= hold_left - 1;
			frame_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left     <= stall_left - 1;
			frame_if.ready <= 1'b0;
		end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
			stall_left     <= $urandom_range(0, 15);
			frame_if.ready <= 1'b0;
		end else begin
			frame_if.ready <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		frame_item_t want;
		frame_item_t got;
		if (arst_n && frame_if.valid && frame_if.ready) begin
			got = frame_if.data;
			if (frame_expect.size() == 0) begin
				note_mismatch("unexpected item, frames_seen", 16'h0, got.frames_seen);
			end else begin
				want = frame_expect.pop_front();
				check_field("frame_type", want.frame_type, got.frame_type);
				check_field("level_0", want.level_0, got.level_0);
				check_field("level_1", want.level_1, got.level_1);
				check_field("level_2", want.level_2, got.level_2);
				check_field("level_3", want.level_3, got.level_3);
				check_field("level_4", want.level_4, got.level_4);
				check_field("level_5", want.level_5, got.level_5);
				check_field("level_6", want.level_6, got.level_6);
				check_field("level_7", want.level_7, got.level_7);
				check_field("level_8", want.level_8, got.level_8);
				check_field("frame_check", want.frame_check, got.frame_check);
				check_field("frames_seen", want.frames_seen, got.frames_seen);
			end
			frames_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int         pick;
		int         n;
		int         rand_start;
		int         rand_frames;
		logic [7:0] kind;
		logic [3:0] gen_last;

		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.data     = '0;
		frame_if.ready = 1'b0;
		cycle_cnt      = 0;
		bytes_taken    = 0;
		mismatch_cnt   = 0;
		frames_checked = 0;
		rand_frames    = 0;

		for (int i = 0; i < BUF_DEPTH; i++)
			win_buf[i] = 8'h00;
		for (int i = 0; i < LEVEL_COUNT; i++)
			held_level[i] = 8'h00;
		collecting  = 1'b0;
		wr_pos      = 4'd0;
		last_pos    = 4'd0;
		held_check  = 8'h00;
		frame_count = 16'h0;

		// Last index still zero from reset: with type FF each frame is one ignored
		// byte, and 00 FF re-forms the header window.
		queue_header(SYNC_HI);
		for (int k = 0; k < ZERO_LAST_FRAMES; k++) begin
			if (k == 0)
				rx_pending.push_back(SYNC_LO);
			else if (k == 1)
				rx_pending.push_back(SYNC_HI);
			else
				rx_pending.push_back(pick_byte());
			if (k < ZERO_LAST_FRAMES - 1) begin
				rx_pending.push_back(SYNC_LO);
				rx_pending.push_back(SYNC_HI);
			end
		end
		idle_from = rx_pending.size();

		// full frame with extreme levels and checksum
		queue_header(TYPE_FULL);
		foreach (kind_list_full[i])
			rx_pending.push_back(kind_list_full[i]);
		// short frame: held levels must come back unchanged
		queue_header(TYPE_SHORT);
		foreach (kind_list_short[i])
			rx_pending.push_back(kind_list_short[i]);

		rand_start = rx_pending.size();
		hold_at    = rand_start + 100;
		gen_last   = LAST_SHORT;
		while (rx_pending.size() - rand_start < RAND_BYTES || rand_frames < RAND_FRAMES) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 4))
					rx_pending.push_back(pick_byte());
			end else if (pick == 1) begin
				// broken: header cut short, or frame cut short
				if ($urandom_range(0, 1)) begin
					rx_pending.push_back(SYNC_HI);
					rx_pending.push_back(SYNC_LO);
					rx_pending.push_back(SYNC_HI);
				end else begin
					queue_header($urandom_range(0, 1) ? TYPE_FULL : TYPE_SHORT);
				end
				repeat ($urandom_range(0, 3))
					rx_pending.push_back(pick_byte());
			end else begin
				n = $urandom_range(0, 9);
				if (n < 4)
					kind = TYPE_FULL;
				else if (n < 7)
					kind = TYPE_SHORT;
				else
					kind = 8'($urandom_range(0, 255));
				queue_header(kind);
				if (kind == TYPE_FULL)
					gen_last = LAST_FULL;
				else if (kind == TYPE_SHORT)
					gen_last = LAST_SHORT;
				n = (gen_last < FIRST_POS) ? 1 : gen_last - FIRST_POS + 1;
				repeat (n)
					rx_pending.push_back(pick_byte());
				rand_frames++;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_pending.size() != 0 || rx_if.valid)
			@(posedge clk);
		while (frame_expect.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_cnt == 0 && frame_expect.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* header_sync_frame_receiver_unit.f */
hdl/hsfr_pkg.sv
hdl/hsfr_stream_if.sv
hdl/hsfr_in_stage.sv
hdl/hsfr_core.sv
hdl/header_sync_frame_receiver_unit.sv
hdl/hsfr_checker.sv
bench/tb_header_sync_frame_receiver_unit.sv
